@@ rtl/sfs_pkg.sv @@
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared constants, types and helper functions of the SPI memory slave.
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int MEM_DEPTH = 512;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // Depth of the queue between the frame decoder and the array side.
  localparam int ACT_DEPTH  = 4;
  localparam int ACT_PTR_W  = $clog2(ACT_DEPTH);
  localparam int ACT_CNT_W  = $clog2(ACT_DEPTH + 1);

  // Depth of the result queue.
  localparam int OUT_DEPTH  = 4;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  // Instruction codes, with the address bit masked off.
  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_WRDI  = 8'h04;
  localparam logic [7:0] OP_WRSR  = 8'h01;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] OP_WRITE = 8'h02;
  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] OP_MASK  = 8'hF7;

  localparam int PROT_QUARTER = MEM_DEPTH / 4 * 3;
  localparam int PROT_HALF    = MEM_DEPTH / 2;

  typedef enum logic [1:0] {
    ACT_PASS,
    ACT_READ,
    ACT_WRITE
  } act_kind_t;

  // One unit of work for the array side: pass a byte through, read, or write.
  typedef struct packed {
    act_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } act_t;

  function automatic logic is_protected(input logic [1:0] bp,
                                        input logic [ADDR_W-1:0] addr);
    logic prot;
    prot = 1'b0;
    case (bp)
      2'd1:    prot = (addr >= ADDR_W'(PROT_QUARTER));
      2'd2:    prot = (addr >= ADDR_W'(PROT_HALF));
      2'd3:    prot = 1'b1;
      default: prot = 1'b0;
    endcase
    return prot;
  endfunction

  // Opcode bit 3 selects the upper half; it is dropped on a smaller array.
  function automatic logic [ADDR_W-1:0] addr_from_opcode(input logic [7:0] b);
    logic [8:0] wide;
    wide = {b[3], 8'h00};
    return ADDR_W'(wide);
  endfunction

  function automatic logic [ADDR_W-1:0] addr_low_load(input logic [ADDR_W-1:0] ptr,
                                                       input logic [7:0] b);
    logic [8:0] wide;
    wide = (9'(ptr) & 9'h100) | {1'b0, b};
    return ADDR_W'(wide);
  endfunction

endpackage

@@ rtl/sfs_frontend.sv @@
// ----------------------------------------------------------------------------
// sfs_frontend
// Frame decoder: tracks opcode, address and data phases, owns the write
// enable latch and block protect bits, and issues one action per byte.
// ----------------------------------------------------------------------------
module sfs_frontend import sfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       opcode,
  input  logic       first_in_frame,
  input  logic [7:0] mosi_byte,
  input  logic       protect_pin_n,
  output logic       act_valid,
  output act_t       act
);

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_WREN,
    CMD_WRDI,
    CMD_RDSR,
    CMD_WRSR,
    CMD_READ,
    CMD_WRITE,
    CMD_BAD
  } cmd_t;

  typedef enum logic [1:0] {
    PH_OPCODE,
    PH_ADDR,
    PH_DATA,
    PH_IGNORE
  } phase_t;

  cmd_t              cmd, cmd_next;
  phase_t            phase, phase_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic              latch, latch_next;
  logic [1:0]        bp, bp_next;
  logic              wrote, wrote_next;
  logic [7:0]        code;

  assign code = mosi_byte & OP_MASK;

  always_comb begin
    cmd_next   = cmd;
    phase_next = phase;
    ptr_next   = ptr;
    latch_next = latch;
    bp_next    = bp;
    wrote_next = wrote;
    act_valid  = 1'b0;
    act.kind   = ACT_PASS;
    act.addr   = ptr;
    act.data   = 8'h00;

    if (accept && opcode) begin
      // Chip select released: a write frame drops the latch.
      if (wrote) begin
        latch_next = 1'b0;
      end
      wrote_next = 1'b0;
      cmd_next   = CMD_NONE;
      phase_next = PH_OPCODE;
    end else if (accept) begin
      act_valid = 1'b1;
      if (first_in_frame || phase == PH_OPCODE) begin
        wrote_next = 1'b0;
        phase_next = PH_IGNORE;
        cmd_next   = CMD_BAD;
        if (code == OP_WREN) begin
          cmd_next   = CMD_WREN;
          latch_next = 1'b1;
        end else if (code == OP_WRDI) begin
          cmd_next   = CMD_WRDI;
          latch_next = 1'b0;
        end else if (code == OP_RDSR) begin
          cmd_next   = CMD_RDSR;
          phase_next = PH_DATA;
        end else if (code == OP_WRSR) begin
          cmd_next   = CMD_WRSR;
          phase_next = PH_DATA;
        end else if (code == OP_READ || code == OP_WRITE) begin
          cmd_next   = (code == OP_READ) ? CMD_READ : CMD_WRITE;
          phase_next = PH_ADDR;
          ptr_next   = addr_from_opcode(mosi_byte);
        end
      end else if (phase == PH_ADDR) begin
        ptr_next   = addr_low_load(ptr, mosi_byte);
        phase_next = PH_DATA;
      end else if (phase == PH_DATA) begin
        case (cmd)
          CMD_RDSR: begin
            act.data = {4'b0000, bp, latch, 1'b0};
          end
          CMD_WRSR: begin
            if (latch && protect_pin_n) begin
              bp_next = mosi_byte[3:2];
            end
            wrote_next = 1'b1;
            phase_next = PH_IGNORE;
          end
          CMD_READ: begin
            act.kind = ACT_READ;
            ptr_next = ptr + 1'b1;
          end
          CMD_WRITE: begin
            if (latch && protect_pin_n && !is_protected(bp, ptr)) begin
              act.kind = ACT_WRITE;
              act.data = mosi_byte;
            end
            wrote_next = 1'b1;
            ptr_next   = ptr + 1'b1;
          end
          default: begin
            phase_next = PH_IGNORE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd   <= CMD_NONE;
      phase <= PH_OPCODE;
      ptr   <= '0;
      latch <= 1'b0;
      bp    <= 2'b00;
      wrote <= 1'b0;
    end else begin
      cmd   <= cmd_next;
      phase <= phase_next;
      ptr   <= ptr_next;
      latch <= latch_next;
      bp    <= bp_next;
      wrote <= wrote_next;
    end
  end

endmodule

@@ rtl/sfs_act_queue.sv @@
// ----------------------------------------------------------------------------
// sfs_act_queue
// Short first-in first-out queue of actions between decoder and array side.
// ----------------------------------------------------------------------------
module sfs_act_queue import sfs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  act_t wr_act,
  input  logic rd_en,
  output act_t rd_act,
  output logic full,
  output logic empty
);

  act_t                 slots [ACT_DEPTH];
  logic [ACT_PTR_W-1:0] wr_ptr;
  logic [ACT_PTR_W-1:0] rd_ptr;
  logic [ACT_CNT_W-1:0] count;

  assign full   = (count == ACT_CNT_W'(ACT_DEPTH));
  assign empty  = (count == '0);
  assign rd_act = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_act;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/sfs_backend.sv @@
// ----------------------------------------------------------------------------
// sfs_backend
// Array side: clears the byte array after reset, carries out reads and
// writes in order, and buffers the returned bytes for the master.
// ----------------------------------------------------------------------------
module sfs_backend import sfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       act_empty,
  input  act_t       act,
  output logic       act_pop,
  output logic       busy,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] miso_byte
);

  logic [7:0]           mem [MEM_DEPTH];
  logic                 clearing;
  logic [ADDR_W-1:0]    clr_addr;
  logic                 s1_valid;
  act_kind_t            s1_kind;
  logic [7:0]           s1_data;
  logic [7:0]           rd_data;
  logic [7:0]           out_value;
  logic [7:0]           out_slots [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] out_wr_ptr;
  logic [OUT_PTR_W-1:0] out_rd_ptr;
  logic [OUT_CNT_W-1:0] out_count;
  logic                 out_pop;

  assign busy = clearing;

  // An action is issued only when the result queue has room for it and for
  // the one already in flight.
  assign act_pop = !act_empty && !clearing &&
                   ((out_count + OUT_CNT_W'(s1_valid)) < OUT_CNT_W'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 8'h00;
    end else if (act_pop && act.kind == ACT_WRITE) begin
      mem[act.addr] <= act.data;
    end
    if (act_pop) begin
      rd_data <= mem[act.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      s1_valid <= act_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (act_pop) begin
      s1_kind <= act.kind;
      s1_data <= act.data;
    end
  end

  always_comb begin
    case (s1_kind)
      ACT_READ:  out_value = rd_data;
      ACT_WRITE: out_value = 8'h00;
      default:   out_value = s1_data;
    endcase
  end

  assign out_pop   = pop && !empty;
  assign empty     = (out_count == '0);
  assign miso_byte = out_slots[out_rd_ptr];

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      out_slots[out_wr_ptr] <= out_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr_ptr <= '0;
      out_rd_ptr <= '0;
      out_count  <= '0;
    end else begin
      if (s1_valid) begin
        out_wr_ptr <= out_wr_ptr + 1'b1;
      end
      if (out_pop) begin
        out_rd_ptr <= out_rd_ptr + 1'b1;
      end
      if (s1_valid && !out_pop) begin
        out_count <= out_count + 1'b1;
      end else if (out_pop && !s1_valid) begin
        out_count <= out_count - 1'b1;
      end
    end
  end

  a_no_issue_while_clearing: assert property (
    @(posedge clk) disable iff (rst) clearing |-> !act_pop)
    else $error("action issued during the clearing pass");

  a_result_has_room: assert property (
    @(posedge clk) disable iff (rst) s1_valid |-> out_count < OUT_CNT_W'(OUT_DEPTH))
    else $error("result written into a full result queue");

  a_clear_ends_at_top: assert property (
    @(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_addr) == ADDR_W'(MEM_DEPTH - 1))
    else $error("clearing pass ended before the last address");

  a_count_bound: assert property (
    @(posedge clk) disable iff (rst) out_count <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result count out of range");

endmodule

@@ rtl/spi_fram_slave_512x8.sv @@
// ----------------------------------------------------------------------------
// spi_fram_slave_512x8
// Byte-level model of a 512 x 8 SPI serial memory slave.
// ----------------------------------------------------------------------------
// Each input transaction is one SPI byte exchanged while select is low, or a
// select release (opcode high). Push an item while full is low; every byte
// yields exactly one miso_byte result, a release yields none. Results leave
// through a queue: read miso_byte while empty is low and raise pop to take it.
// The frame decoder takes one item per clock while full is low, so the
// sustained rate is one item per cycle. A byte's result is visible once it
// has passed the action queue, the array read register and the result
// queue. After reset the array is cleared one address per cycle; full stays
// high until the last address is cleared. When pop is held low, the
// four-entry result and action queues fill and full rises; nothing is lost
// and the decoder state advances only on accepted transactions.
// ----------------------------------------------------------------------------
module spi_fram_slave_512x8 import sfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       opcode,
  input  logic       first_in_frame,
  input  logic [7:0] mosi_byte,
  input  logic       protect_pin_n,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] miso_byte
);

  logic accept;
  logic act_valid;
  act_t act_in;
  act_t act_out;
  logic act_full;
  logic act_empty;
  logic act_pop;
  logic busy;

  assign full   = act_full || busy;
  assign accept = push && !full;

  sfs_frontend u_frontend (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .opcode         (opcode),
    .first_in_frame (first_in_frame),
    .mosi_byte      (mosi_byte),
    .protect_pin_n  (protect_pin_n),
    .act_valid      (act_valid),
    .act            (act_in)
  );

  sfs_act_queue u_act_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (act_valid),
    .wr_act (act_in),
    .rd_en  (act_pop),
    .rd_act (act_out),
    .full   (act_full),
    .empty  (act_empty)
  );

  sfs_backend u_backend (
    .clk       (clk),
    .rst       (rst),
    .act_empty (act_empty),
    .act       (act_out),
    .act_pop   (act_pop),
    .busy      (busy),
    .pop       (pop),
    .empty     (empty),
    .miso_byte (miso_byte)
  );

endmodule
